>>> sv/lattice_trilinear_interpolator_unit_macros.svh
// Assertion macros used by the asserting top-level file.
`ifndef LATTICE_TRILINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define LATTICE_TRILINEAR_INTERPOLATOR_UNIT_MACROS_SVH

// Check cons in the same cycle as ante.
`define LTRI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ltri check failed");

// Check cons in the cycle after ante.
`define LTRI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ltri check failed");

`endif

>>> sv/ltri_pkg.sv
package ltri_pkg;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [2:0] REG_TAU_ORIGIN   = 3'd0;
    localparam logic [2:0] REG_X_ORIGIN     = 3'd1;
    localparam logic [2:0] REG_Y_ORIGIN     = 3'd2;
    localparam logic [2:0] REG_TAU_INV_STEP = 3'd3;
    localparam logic [2:0] REG_X_INV_STEP   = 3'd4;
    localparam logic [2:0] REG_Y_INV_STEP   = 3'd5;
    localparam logic [2:0] REG_FRAME_COUNT  = 3'd6;
    localparam logic [2:0] REG_VISCOUS_EN   = 3'd7;

    localparam int VISCOUS_FIRST = 6;
    localparam int OUT_DEPTH     = 8;

    typedef struct packed {
        logic               command;
        logic [2:0]         load_frame;
        logic [4:0]         load_x;
        logic [4:0]         load_y;
        logic [4:0]         load_channel;
        logic signed [31:0] load_value;
        logic               ok;
        logic [5:0]         ti;
        logic [9:0]         xi;
        logic [9:0]         yi;
        logic [15:0]        tf;
        logic [15:0]        xf;
        logic [15:0]        yf;
    } job_t;

    typedef struct packed {
        logic [4:0]  channel;
        logic        zero;
        logic        ok;
        logic        last;
        logic [2:0]  par;
        logic [15:0] tf;
        logic [15:0] xf;
        logic [15:0] yf;
    } meta_t;

    typedef struct packed {
        logic [4:0]         channel;
        logic signed [31:0] value;
        logic               in_range;
        logic               last;
    } res_t;

endpackage

>>> sv/ltri_ram.sv
module ltri_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/ltri_front.sv
module ltri_front
    import ltri_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int X_POINTS   = 32,
    parameter int Y_POINTS   = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               command,
    input  logic [2:0]         load_frame,
    input  logic [4:0]         load_x,
    input  logic [4:0]         load_y,
    input  logic [4:0]         load_channel,
    input  logic signed [31:0] load_value,
    input  logic signed [31:0] query_tau,
    input  logic signed [31:0] query_x,
    input  logic signed [31:0] query_y,
    input  logic signed [31:0] tau_origin,
    input  logic signed [31:0] x_origin,
    input  logic signed [31:0] y_origin,
    input  logic [31:0]        tau_inv_step,
    input  logic [31:0]        x_inv_step,
    input  logic [31:0]        y_inv_step,
    input  logic [3:0]         frame_count,
    output logic               q_valid,
    output job_t               q_head,
    input  logic               q_pop
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CALC = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t            state_reg;
    logic               cmd_reg;
    logic [2:0]         lf_reg;
    logic [4:0]         lx_reg;
    logic [4:0]         ly_reg;
    logic [4:0]         lc_reg;
    logic signed [31:0] lv_reg;
    logic [32:0]        dt_reg;
    logic [32:0]        dx_reg;
    logic [32:0]        dy_reg;
    logic [63:0]        pt_reg;
    logic [63:0]        px_reg;
    logic [63:0]        py_reg;
    logic [2:0]         neg_reg;

    job_t               q_mem_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         cnt_reg;

    logic [31:0]        fc_eff;
    logic               ok;
    logic               do_push;
    job_t               job;

    assign full    = (state_reg != F_IDLE);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_head  = q_mem_reg[rd_ptr_reg];
    assign do_push = (state_reg == F_PUSH) && (cnt_reg != 2'd2);

    always_comb
    begin
        fc_eff = (32'(frame_count) > 32'(MAX_FRAMES)) ? 32'(MAX_FRAMES) : 32'(frame_count);
        ok = (neg_reg == 3'b000) && (fc_eff >= 32'd2)
            && (pt_reg[63:32] < fc_eff - 32'd1)
            && (px_reg[63:32] < 32'(X_POINTS - 1))
            && (py_reg[63:32] < 32'(Y_POINTS - 1));
        job.command      = cmd_reg;
        job.load_frame   = lf_reg;
        job.load_x       = lx_reg;
        job.load_y       = ly_reg;
        job.load_channel = lc_reg;
        job.load_value   = lv_reg;
        job.ok           = ok;
        job.ti           = pt_reg[37:32];
        job.xi           = px_reg[41:32];
        job.yi           = py_reg[41:32];
        job.tf           = pt_reg[31:16];
        job.xf           = px_reg[31:16];
        job.yf           = py_reg[31:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (push)
                    begin
                        state_reg <= F_CALC;
                    end
                end
                F_CALC:
                begin
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (do_push)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == F_IDLE) && push)
        begin
            cmd_reg <= command;
            lf_reg  <= load_frame;
            lx_reg  <= load_x;
            ly_reg  <= load_y;
            lc_reg  <= load_channel;
            lv_reg  <= load_value;
            dt_reg  <= {query_tau[31], query_tau} - {tau_origin[31], tau_origin};
            dx_reg  <= {query_x[31], query_x} - {x_origin[31], x_origin};
            dy_reg  <= {query_y[31], query_y} - {y_origin[31], y_origin};
        end
        if (state_reg == F_CALC)
        begin
            pt_reg  <= 64'(dt_reg[31:0]) * 64'(tau_inv_step);
            px_reg  <= 64'(dx_reg[31:0]) * 64'(x_inv_step);
            py_reg  <= 64'(dy_reg[31:0]) * 64'(y_inv_step);
            neg_reg <= {dt_reg[32], dx_reg[32], dy_reg[32]};
        end
        if (do_push)
        begin
            q_mem_reg[wr_ptr_reg] <= job;
        end
    end

endmodule

>>> sv/ltri_back.sv
module ltri_back
    import ltri_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int X_POINTS   = 32,
    parameter int Y_POINTS   = 32,
    parameter int CHANNELS   = 17
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  job_t               q_head,
    output logic               q_pop,
    input  logic               viscous_enable,
    output logic               empty,
    input  logic               pop,
    output res_t               res
);

    localparam int FW  = ($clog2(MAX_FRAMES) > 0) ? $clog2(MAX_FRAMES) : 1;
    localparam int XW  = $clog2(X_POINTS);
    localparam int YW  = $clog2(Y_POINTS);
    localparam int CW  = $clog2(CHANNELS);
    localparam int FHW = ($clog2((MAX_FRAMES + 1) / 2) > 0) ? $clog2((MAX_FRAMES + 1) / 2) : 1;
    localparam int XHW = ($clog2((X_POINTS + 1) / 2) > 0) ? $clog2((X_POINTS + 1) / 2) : 1;
    localparam int YHW = ($clog2((Y_POINTS + 1) / 2) > 0) ? $clog2((Y_POINTS + 1) / 2) : 1;
    localparam int AW  = FHW + XHW + YHW + CW;
    localparam int PW  = $clog2(OUT_DEPTH);

    function automatic logic signed [31:0] lerp(
        input logic signed [31:0] a,
        input logic signed [31:0] b,
        input logic [15:0]        f
    );
        logic signed [17:0] wa;
        logic signed [17:0] wb;
        logic signed [50:0] s;
        wa = 18'sd65536 - $signed({2'b00, f});
        wb = $signed({2'b00, f});
        s  = 51'(a) * 51'(wa) + 51'(b) * 51'(wb) + 51'sd32768;
        return s[47:16];
    endfunction

    logic [CW-1:0]       ch_reg;
    logic                is_load;
    logic                load_ok;
    logic [2:0]          lbank;
    logic [AW-1:0]       laddr;
    logic                room;
    logic                issue;
    logic [FW-1:0]       ti;
    logic [FW-1:0]       ti1;
    logic [XW-1:0]       xi;
    logic [XW-1:0]       xi1;
    logic [YW-1:0]       yi;
    logic [YW-1:0]       yi1;
    logic [31:0]         rd [8];
    logic [AW-1:0]       raddr [8];
    meta_t               meta;

    logic                s1_reg, s2_reg, s3_reg, s4_reg;
    meta_t               m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [31:0]  x_reg [4];
    logic signed [31:0]  y_reg [2];
    logic signed [31:0]  v_reg;

    res_t                ob_mem_reg [OUT_DEPTH];
    logic [PW-1:0]       ob_wr_reg;
    logic [PW-1:0]       ob_rd_reg;
    logic [PW:0]         ob_cnt_reg;
    logic                ob_pop;
    res_t                ob_in;

    assign is_load = (q_head.command == CMD_LOAD);
    assign room    = (ob_cnt_reg + (PW + 1)'(s1_reg) + (PW + 1)'(s2_reg)
                     + (PW + 1)'(s3_reg) + (PW + 1)'(s4_reg)) < (PW + 1)'(OUT_DEPTH);
    assign issue   = q_valid && !is_load && room;
    assign q_pop   = q_valid && (is_load || (issue && (ch_reg == CW'(CHANNELS - 1))));
    assign load_ok = q_valid && is_load
        && (32'(q_head.load_frame) < 32'(MAX_FRAMES))
        && (32'(q_head.load_x) < 32'(X_POINTS))
        && (32'(q_head.load_y) < 32'(Y_POINTS))
        && (32'(q_head.load_channel) < 32'(CHANNELS));
    assign lbank   = {q_head.load_frame[0], q_head.load_x[0], q_head.load_y[0]};
    assign laddr   = {FHW'(q_head.load_frame >> 1), XHW'(q_head.load_x >> 1),
                      YHW'(q_head.load_y >> 1), CW'(q_head.load_channel)};

    assign ti  = q_head.ti[FW-1:0];
    assign ti1 = ti + FW'(1);
    assign xi  = q_head.xi[XW-1:0];
    assign xi1 = xi + XW'(1);
    assign yi  = q_head.yi[YW-1:0];
    assign yi1 = yi + YW'(1);

    always_comb
    begin
        meta.channel = 5'(ch_reg);
        meta.zero    = !q_head.ok || ((ch_reg >= CW'(VISCOUS_FIRST)) && !viscous_enable);
        meta.ok      = q_head.ok;
        meta.last    = (ch_reg == CW'(CHANNELS - 1));
        meta.par     = {ti[0], xi[0], yi[0]};
        meta.tf      = q_head.tf;
        meta.xf      = q_head.xf;
        meta.yf      = q_head.yf;
    end

    for (genvar b = 0; b < 8; b++)
    begin : g_bank
        localparam logic PF = 1'((b / 4) % 2);
        localparam logic PX = 1'((b / 2) % 2);
        localparam logic PY = 1'(b % 2);
        logic [FW-1:0] fb;
        logic [XW-1:0] xb;
        logic [YW-1:0] yb;

        assign fb = (ti[0] == PF) ? ti : ti1;
        assign xb = (xi[0] == PX) ? xi : xi1;
        assign yb = (yi[0] == PY) ? yi : yi1;
        assign raddr[b] = {FHW'(fb >> 1), XHW'(xb >> 1), YHW'(yb >> 1), ch_reg};

        ltri_ram #(
            .WIDTH(32),
            .DEPTH(2 ** AW)
        ) u_ram (
            .clk  (clk),
            .we   (load_ok && (lbank == 3'(b))),
            .waddr(laddr),
            .wdata(q_head.load_value),
            .raddr(raddr[b]),
            .rdata(rd[b])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg <= '0;
            s1_reg <= 1'b0;
            s2_reg <= 1'b0;
            s3_reg <= 1'b0;
            s4_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                ch_reg <= (ch_reg == CW'(CHANNELS - 1)) ? '0 : ch_reg + CW'(1);
            end
            s1_reg <= issue;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            s4_reg <= s3_reg;
        end
    end

    // Corner at (dt,dx,dy) sits in bank {tpar^dt, xpar^dx, ypar^dy}.
    always_ff @(posedge clk)
    begin
        m1_reg   <= meta;
        m2_reg   <= m1_reg;
        m3_reg   <= m2_reg;
        m4_reg   <= m3_reg;
        x_reg[0] <= lerp(rd[m1_reg.par ^ 3'b000], rd[m1_reg.par ^ 3'b010], m1_reg.xf);
        x_reg[1] <= lerp(rd[m1_reg.par ^ 3'b001], rd[m1_reg.par ^ 3'b011], m1_reg.xf);
        x_reg[2] <= lerp(rd[m1_reg.par ^ 3'b100], rd[m1_reg.par ^ 3'b110], m1_reg.xf);
        x_reg[3] <= lerp(rd[m1_reg.par ^ 3'b101], rd[m1_reg.par ^ 3'b111], m1_reg.xf);
        y_reg[0] <= lerp(x_reg[0], x_reg[1], m2_reg.yf);
        y_reg[1] <= lerp(x_reg[2], x_reg[3], m2_reg.yf);
        v_reg    <= lerp(y_reg[0], y_reg[1], m3_reg.tf);
    end

    assign ob_in.channel  = m4_reg.channel;
    assign ob_in.value    = m4_reg.zero ? 32'sd0 : v_reg;
    assign ob_in.in_range = m4_reg.ok;
    assign ob_in.last     = m4_reg.last;

    assign empty  = (ob_cnt_reg == '0);
    assign ob_pop = pop && !empty;
    assign res    = ob_mem_reg[ob_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_wr_reg  <= '0;
            ob_rd_reg  <= '0;
            ob_cnt_reg <= '0;
        end
        else
        begin
            if (s4_reg)
            begin
                ob_wr_reg <= ob_wr_reg + PW'(1);
            end
            if (ob_pop)
            begin
                ob_rd_reg <= ob_rd_reg + PW'(1);
            end
            ob_cnt_reg <= ob_cnt_reg + (PW + 1)'(s4_reg) - (PW + 1)'(ob_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_reg)
        begin
            ob_mem_reg[ob_wr_reg] <= ob_in;
        end
    end

endmodule

>>> sv/lattice_trilinear_interpolator_unit.sv
// Channel   Handshake          Beat contents
// input     push / full        command, load_*, query_tau, query_x, query_y
// result    empty / pop        channel, value, in_range, last
// config    cfg_write          cfg_index, cfg_data
//
// A query issues one channel a cycle while the result queue has room, set by the single read
// port of each of the eight corner banks; each beat in takes the front mapper through F_CALC
// and F_PUSH (full high in both); the front runs ahead of the back end through a 2-entry queue.
// Loads write a bank from the queue head; query channels pass the bank read and x, y, tau lerps.
// Reset clears control state only; grid contents are undefined until loaded.
// The result queue holds 8 beats; the back end halts issue when it would overflow.
`include "lattice_trilinear_interpolator_unit_macros.svh"
module lattice_trilinear_interpolator_unit
    import ltri_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int X_POINTS   = 32,
    parameter int Y_POINTS   = 32,
    parameter int CHANNELS   = 17
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               command,
    input  logic [2:0]         load_frame,
    input  logic [4:0]         load_x,
    input  logic [4:0]         load_y,
    input  logic [4:0]         load_channel,
    input  logic signed [31:0] load_value,
    input  logic signed [31:0] query_tau,
    input  logic signed [31:0] query_x,
    input  logic signed [31:0] query_y,
    output logic               empty,
    input  logic               pop,
    output logic [4:0]         channel,
    output logic signed [31:0] value,
    output logic               in_range,
    output logic               last,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic signed [31:0] tau_origin_reg;
    logic signed [31:0] x_origin_reg;
    logic signed [31:0] y_origin_reg;
    logic [31:0]        tau_inv_reg;
    logic [31:0]        x_inv_reg;
    logic [31:0]        y_inv_reg;
    logic [3:0]         frame_count_reg;
    logic               viscous_reg;

    logic               q_valid;
    logic               q_pop;
    job_t               q_head;
    res_t               res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tau_origin_reg  <= 32'sd0;
            x_origin_reg    <= 32'sd0;
            y_origin_reg    <= 32'sd0;
            tau_inv_reg     <= 32'd65536;
            x_inv_reg       <= 32'd65536;
            y_inv_reg       <= 32'd65536;
            frame_count_reg <= 4'd8;
            viscous_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TAU_ORIGIN:   tau_origin_reg  <= cfg_data;
                REG_X_ORIGIN:     x_origin_reg    <= cfg_data;
                REG_Y_ORIGIN:     y_origin_reg    <= cfg_data;
                REG_TAU_INV_STEP: tau_inv_reg     <= cfg_data;
                REG_X_INV_STEP:   x_inv_reg       <= cfg_data;
                REG_Y_INV_STEP:   y_inv_reg       <= cfg_data;
                REG_FRAME_COUNT:  frame_count_reg <= cfg_data[3:0];
                REG_VISCOUS_EN:   viscous_reg     <= cfg_data[0];
                default:          viscous_reg     <= viscous_reg;
            endcase
        end
    end

    ltri_front #(
        .MAX_FRAMES(MAX_FRAMES),
        .X_POINTS  (X_POINTS),
        .Y_POINTS  (Y_POINTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .load_frame  (load_frame),
        .load_x      (load_x),
        .load_y      (load_y),
        .load_channel(load_channel),
        .load_value  (load_value),
        .query_tau   (query_tau),
        .query_x     (query_x),
        .query_y     (query_y),
        .tau_origin  (tau_origin_reg),
        .x_origin    (x_origin_reg),
        .y_origin    (y_origin_reg),
        .tau_inv_step(tau_inv_reg),
        .x_inv_step  (x_inv_reg),
        .y_inv_step  (y_inv_reg),
        .frame_count (frame_count_reg),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop)
    );

    ltri_back #(
        .MAX_FRAMES(MAX_FRAMES),
        .X_POINTS  (X_POINTS),
        .Y_POINTS  (Y_POINTS),
        .CHANNELS  (CHANNELS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .viscous_enable(viscous_reg),
        .empty         (empty),
        .pop           (pop),
        .res           (res)
    );

    assign channel  = res.channel;
    assign value    = res.value;
    assign in_range = res.in_range;
    assign last     = res.last;

    `LTRI_ASSERT_NOW(a_last_channel, !empty && last, channel == 5'(CHANNELS - 1))
    `LTRI_ASSERT_NOW(a_out_zero, !empty && !in_range, value == 32'sd0)
    `LTRI_ASSERT_NOW(a_visc_zero, !empty && !viscous_reg && (channel >= 5'(VISCOUS_FIRST)), value == 32'sd0)
    `LTRI_ASSERT_NEXT(a_pop_empty, q_pop && !q_valid, 1'b0)

endmodule
